// ===== rtl/core/rbtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtm_pkg: shared definitions for the rolling below-threshold mean
// Field widths, register indexes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbtm_pkg;

  // Default depth of the sample ring.
  localparam int WINDOW_MAX_DEFAULT = 64;

  // Fixed field widths.
  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 16;
  localparam int QFRAC_W    = 17;
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Quantile level of one, in Q1.16.
  localparam logic [QFRAC_W-1:0] QFRAC_ONE = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAST_COUNT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_FRACTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN              = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE        = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;
    logic decide;
    logic sum_go;
    logic rank_go;
    logic rank_end;
    logic prep;
    logic sel_go;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_res;
    logic out_fill;
  } rbtm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_due;
    logic mode_mean;
    logic scan_idle;
    logic cand_last;
    logic div_last;
    logic out_free;
  } rbtm_status_t;

endpackage

// ===== rtl/core/rolling_below_threshold_mean_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_below_threshold_mean_top: lower-part mean over a sliding window
// Each sample word gives one result word: gain/256 times the mean of window
// samples at or below a mean or quantile threshold, or the fill value.
// ----------------------------------------------------------------------------
// Use:
//   Samples enter on sample/sample_valid/sample_ready; results leave on
//   result, is_fill, saturated with result_valid/result_ready. Configuration
//   is written through cfg_write/cfg_index/cfg_data while the block is idle.
//   One word is processed at a time; sample_ready is high only when idle.
// Steps per word, with n the window size:
//   fill result: store, decision, then the output register.
//   mean threshold: two ring scans (sum and select), multiply, divider.
//   quantile threshold: sum scan, n rank passes, select scan, multiply and
//   divider; each of the n rank passes reads the single ring port once per
//   window sample.
// The next word is taken as soon as a result is in the output register, so
// a held result stalls the block only when the following result is ready.
// Reset clears the controller, pointers, counts and configuration; ring
// contents are not cleared, and no scan uses an entry before it is written.
// ----------------------------------------------------------------------------
module rolling_below_threshold_mean_top
  import rbtm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic signed [SAMPLE_W-1:0]  result,
  output logic                        is_fill,
  output logic                        saturated
);

  rbtm_cmd_t    cmd;
  rbtm_status_t status;

  // Sequencer.
  rbtm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Ring, scans, arithmetic and output register.
  rbtm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .is_fill      (is_fill),
    .saturated    (saturated),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== rtl/core/rbtm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtm_ctrl: sequencer for the rolling below-threshold mean
// Steps one word through store, decision, window scans, multiply, divide and
// output, issuing one command set per cycle to the datapath.
// ----------------------------------------------------------------------------
module rbtm_ctrl
  import rbtm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_ready,
  input  rbtm_status_t status,
  output rbtm_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECIDE  = 4'd1;
  localparam logic [3:0] ST_BRANCH  = 4'd2;
  localparam logic [3:0] ST_SUM     = 4'd3;
  localparam logic [3:0] ST_CAND_RD = 4'd4;
  localparam logic [3:0] ST_CAND_WT = 4'd5;
  localparam logic [3:0] ST_RANK    = 4'd6;
  localparam logic [3:0] ST_PREP    = 4'd7;
  localparam logic [3:0] ST_SEL     = 4'd8;
  localparam logic [3:0] ST_MUL     = 4'd9;
  localparam logic [3:0] ST_DIVI    = 4'd10;
  localparam logic [3:0] ST_DIV     = 4'd11;
  localparam logic [3:0] ST_RES     = 4'd12;
  localparam logic [3:0] ST_FILL    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign sample_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.store  = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (status.fill_due) begin
          state_next = ST_FILL;
        end else begin
          cmd.sum_go = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.scan_idle) begin
          if (status.mode_mean) begin
            cmd.sel_go = 1'b1;
            state_next = ST_SEL;
          end else begin
            state_next = ST_CAND_RD;
          end
        end
      end
      ST_CAND_RD: begin
        state_next = ST_CAND_WT;
      end
      ST_CAND_WT: begin
        cmd.rank_go = 1'b1;
        state_next  = ST_RANK;
      end
      ST_RANK: begin
        if (status.scan_idle) begin
          cmd.rank_end = 1'b1;
          state_next   = status.cand_last ? ST_PREP : ST_CAND_RD;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cmd.sel_go = 1'b1;
        state_next = ST_SEL;
      end
      ST_SEL: begin
        if (status.scan_idle) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_RES;
        end
      end
      ST_RES: begin
        if (status.out_free) begin
          cmd.out_res = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd.out_fill = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rbtm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtm_dp: datapath for the rolling below-threshold mean
// Holds the configuration, the sample ring, the window scan engine, the
// threshold logic, the gain multiplier, a restoring divider and the output
// register.
// ----------------------------------------------------------------------------
module rbtm_dp
  import rbtm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   sample,
  input  logic                         result_ready,
  output logic                         result_valid,
  output logic signed [SAMPLE_W-1:0]   result,
  output logic                         is_fill,
  output logic                         saturated,
  input  rbtm_cmd_t                    cmd,
  output rbtm_status_t                 status
);

  localparam int AW  = $clog2(WINDOW_MAX);
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int SW  = SAMPLE_W + CW;
  localparam int PW  = SW + GAIN_W;
  localparam int DW  = PW + 1;
  localparam int RW  = CW + 8;
  localparam int KW  = $clog2(DW);
  localparam int XW  = SAMPLE_W + CW + 1;
  localparam int DFW = SAMPLE_W + 1 + QFRAC_W;
  localparam int PQW = QFRAC_W + CW;

  localparam logic [1:0] PASS_SUM  = 2'd0;
  localparam logic [1:0] PASS_RANK = 2'd1;
  localparam logic [1:0] PASS_SEL  = 2'd2;

  // Configuration registers.
  logic [WLEN_W-1:0]         window_length;
  logic                      partial_enable;
  logic [WLEN_W-1:0]         least_count;
  logic                      threshold_mode;
  logic [QFRAC_W-1:0]        quantile_fraction;
  logic signed [GAIN_W-1:0]  gain;
  logic signed [SAMPLE_W-1:0] fill_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WLEN_W'(1);
      partial_enable    <= 1'b0;
      least_count       <= WLEN_W'(1);
      threshold_mode    <= 1'b1;
      quantile_fraction <= 17'd32768;
      gain              <= 16'sd256;
      fill_value        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:     window_length     <= cfg_data[WLEN_W-1:0];
        REG_PARTIAL_ENABLE:    partial_enable    <= cfg_data[0];
        REG_LEAST_COUNT:       least_count       <= cfg_data[WLEN_W-1:0];
        REG_THRESHOLD_MODE:    threshold_mode    <= cfg_data[0];
        REG_QUANTILE_FRACTION: quantile_fraction <= cfg_data[QFRAC_W-1:0];
        REG_GAIN:              gain              <= cfg_data[GAIN_W-1:0];
        REG_FILL_VALUE:        fill_value        <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring pointer and fill count.
  logic [AW-1:0] write_pointer;
  logic [CW-1:0] samples_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      samples_seen  <= '0;
    end else if (cmd.store) begin
      write_pointer <= (write_pointer == AW'(WINDOW_MAX - 1)) ? '0 : write_pointer + 1'b1;
      if (samples_seen != CW'(WINDOW_MAX)) begin
        samples_seen <= samples_seen + 1'b1;
      end
    end
  end

  // Effective window length, least count and quantile level.
  logic [CW-1:0]      wl_eff;
  logic [WLEN_W-1:0]  least_eff;
  logic [QFRAC_W-1:0] q_eff;

  always_comb begin
    if (window_length == '0) begin
      wl_eff = CW'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      wl_eff = CW'(WINDOW_MAX);
    end else begin
      wl_eff = CW'(window_length);
    end
    least_eff = (least_count == '0) ? WLEN_W'(1) : least_count;
    q_eff     = (quantile_fraction > QFRAC_ONE) ? QFRAC_ONE : quantile_fraction;
  end

  // Window size for this word, or a fill result.
  logic [CW-1:0] n;
  logic          fill_due;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (32'(samples_seen) >= 32'(wl_eff)) begin
        n        <= wl_eff;
        fill_due <= 1'b0;
      end else if (partial_enable && (32'(samples_seen) >= 32'(least_eff))) begin
        n        <= samples_seen;
        fill_due <= 1'b0;
      end else begin
        fill_due <= 1'b1;
      end
    end
  end

  // Quantile position: integer rank and fraction.
  logic [PQW-1:0] qpos;
  logic [CW:0]    r_int;
  logic [CW:0]    ra;
  logic [CW:0]    rb;
  logic [15:0]    f_reg;
  logic           clamp;

  assign qpos  = PQW'(q_eff) * PQW'(n);
  assign r_int = qpos[PQW-1:16];

  always_ff @(posedge clk) begin
    if (cmd.sum_go) begin
      f_reg <= qpos[15:0];
      if (r_int >= ({1'b0, n} - 1'b1)) begin
        clamp <= 1'b1;
        ra    <= {1'b0, n} - 1'b1;
      end else begin
        clamp <= 1'b0;
        ra    <= r_int;
      end
      rb <= r_int + 1'b1;
    end
  end

  // Scan engine: reads the n newest samples, one per cycle.
  logic                       active;
  logic                       rv;
  logic [CW-1:0]              j;
  logic [CW-1:0]              i;
  logic [1:0]                 pass;
  logic [CW-1:0]              back;
  logic [AW:0]                tpos;
  logic [AW-1:0]              raddr;
  logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] rdata;

  assign back = active ? j : i;

  always_comb begin
    tpos = (AW+1)'(write_pointer) + (AW+1)'(WINDOW_MAX - 1) - (AW+1)'(back);
    if (tpos >= (AW+1)'(WINDOW_MAX)) begin
      raddr = AW'(tpos - (AW+1)'(WINDOW_MAX));
    end else begin
      raddr = AW'(tpos);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[write_pointer] <= sample;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rv     <= 1'b0;
    end else begin
      rv <= active;
      if (cmd.sum_go || cmd.rank_go || cmd.sel_go) begin
        active <= 1'b1;
        j      <= '0;
      end else if (active) begin
        j      <= j + 1'b1;
        active <= (j != n - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_go) begin
      pass <= PASS_SUM;
    end else if (cmd.rank_go) begin
      pass <= PASS_RANK;
    end else if (cmd.sel_go) begin
      pass <= PASS_SEL;
    end
  end

  // Candidate loop for the quantile ranks.
  logic signed [SAMPLE_W-1:0] cand;
  logic [CW-1:0]              lt_cnt;
  logic [CW-1:0]              le_cnt;
  logic signed [SAMPLE_W-1:0] sa;
  logic signed [SAMPLE_W-1:0] sb;

  always_ff @(posedge clk) begin
    if (cmd.sum_go) begin
      i <= '0;
    end else if (cmd.rank_end) begin
      i <= i + 1'b1;
    end
    if (cmd.rank_end) begin
      if (((CW+1)'(lt_cnt) <= ra) && (ra < (CW+1)'(le_cnt))) begin
        sa <= cand;
      end
      if (!clamp && ((CW+1)'(lt_cnt) <= rb) && (rb < (CW+1)'(le_cnt))) begin
        sb <= cand;
      end
    end
  end

  // Threshold terms for the quantile test.
  logic signed [SAMPLE_W:0]   dsel;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [DFW-1:0]      df;

  assign dsel = clamp ? '0 : ((SAMPLE_W+1)'(sb) - (SAMPLE_W+1)'(sa));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      base <= sa;
      df   <= DFW'(dsel) * DFW'(signed'({1'b0, f_reg}));
    end
  end

  // Per-sample work on scan data.
  logic signed [SW-1:0]         running_sum;
  logic signed [SW-1:0]         sel_sum;
  logic [CW-1:0]                cnt;
  logic signed [XW-1:0]         xn;
  logic signed [SAMPLE_W:0]     dx;
  logic signed [SAMPLE_W+16:0]  lhs;
  logic                         hit;

  always_comb begin
    xn  = XW'(rdata) * XW'(signed'({1'b0, n}));
    dx  = (SAMPLE_W+1)'(rdata) - (SAMPLE_W+1)'(base);
    lhs = {dx, 16'h0000};
    if (threshold_mode) begin
      hit = (xn <= XW'(running_sum));
    end else begin
      hit = (DFW'(lhs) <= df);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_go) begin
      running_sum <= '0;
    end
    if (cmd.rank_go) begin
      cand   <= rdata;
      lt_cnt <= '0;
      le_cnt <= '0;
    end
    if (cmd.sel_go) begin
      sel_sum <= '0;
      cnt     <= '0;
    end
    if (rv) begin
      case (pass)
        PASS_SUM: running_sum <= running_sum + SW'(rdata);
        PASS_RANK: begin
          if (rdata < cand) begin
            lt_cnt <= lt_cnt + 1'b1;
          end
          if (rdata <= cand) begin
            le_cnt <= le_cnt + 1'b1;
          end
        end
        PASS_SEL: begin
          if (hit) begin
            cnt     <= cnt + 1'b1;
            sel_sum <= sel_sum + SW'(rdata);
          end
        end
        default: ;
      endcase
    end
  end

  // Gain multiply, then rounded division by 256 times the count.
  logic signed [PW-1:0] prod;
  logic [CW-1:0]        cnt1;
  logic [PW-1:0]        mag;
  logic                 neg;
  logic [DW-1:0]        dvd;
  logic [RW-1:0]        divisor;
  logic [RW-1:0]        rem;
  logic [RW:0]          rem_sh;
  logic [KW-1:0]        k;

  assign mag    = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign rem_sh = {rem, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(sel_sum) * PW'(gain);
      cnt1 <= (cnt == '0) ? CW'(1) : cnt;
    end
    if (cmd.div_init) begin
      neg     <= prod[PW-1];
      dvd     <= DW'(mag) + DW'({cnt1, 7'b0});
      divisor <= {cnt1, 8'b0};
      rem     <= '0;
      k       <= '0;
    end else if (cmd.div_step) begin
      k <= k + 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= RW'(rem_sh - {1'b0, divisor});
        dvd <= {dvd[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[RW-1:0];
        dvd <= {dvd[DW-2:0], 1'b0};
      end
    end
  end

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_res || cmd.out_fill) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fill) begin
      result    <= fill_value;
      is_fill   <= 1'b1;
      saturated <= 1'b0;
    end else if (cmd.out_res) begin
      is_fill <= 1'b0;
      if (neg) begin
        if (dvd > DW'(64'd2147483648)) begin
          result    <= 32'sh8000_0000;
          saturated <= 1'b1;
        end else begin
          result    <= -signed'(dvd[SAMPLE_W-1:0]);
          saturated <= 1'b0;
        end
      end else begin
        if (dvd > DW'(64'd2147483647)) begin
          result    <= 32'sh7FFF_FFFF;
          saturated <= 1'b1;
        end else begin
          result    <= dvd[SAMPLE_W-1:0];
          saturated <= 1'b0;
        end
      end
    end
  end

  // Status back to the controller.
  assign status.fill_due  = fill_due;
  assign status.mode_mean = threshold_mode;
  assign status.scan_idle = !active && !rv;
  assign status.cand_last = ((CW+1)'(i) + 1'b1) == (CW+1)'(n);
  assign status.div_last  = (k == KW'(DW - 1));
  assign status.out_free  = !result_valid || result_ready;

`ifndef ASSERT_OFF
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    32'(samples_seen) <= 32'(WINDOW_MAX))
    else $error("samples_seen above ring depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_pointer) < 32'(WINDOW_MAX))
    else $error("write_pointer out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_res || cmd.out_fill) |-> (!result_valid || result_ready))
    else $error("output register overwritten while held");

  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (samples_seen != '0))
    else $error("stored word not counted");
`endif

endmodule
